@@ hw/rtl/stereo_vu_peak_meter_defines.svh @@
// Assertion macros shared by the stereo peak meter RTL.
// Depends on nothing; included by files that carry assertions.
`ifndef STEREO_VU_PEAK_METER_DEFINES_SVH
`define STEREO_VU_PEAK_METER_DEFINES_SVH
// Check an implication on every rising clock edge outside reset.
`define SVPM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a signal holds its value in the cycle after a condition.
`define SVPM_HOLD(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);
`endif

@@ hw/rtl/svpm_pkg.sv @@
// Package for the stereo peak meter: widths, register indexes, opcodes, states.
// Depends on nothing.
package svpm_pkg;
  localparam int unsigned RingDepth = 4096;
  localparam int unsigned SampleWidth = 24;
  localparam int unsigned FracBits = 20;
  localparam int unsigned AddrW = $clog2(RingDepth);
  localparam int unsigned CntW = AddrW + 1;
  localparam int unsigned RingW = 2 * SampleWidth;
  localparam int unsigned MagW = SampleWidth;
  localparam logic [31:0] Log10HalfQ32 = 32'd646456993;

  localparam logic [1:0] RegWindow = 2'd0;
  localparam logic [1:0] RegBar = 2'd1;
  localparam logic [1:0] RegHold = 2'd2;
  localparam logic [1:0] RegDecay = 2'd3;

  localparam logic OpPush = 1'b0;
  localparam logic OpTick = 1'b1;

  typedef enum logic [3:0] {
    StIdle, StScanRd, StScan, StLogInit, StLogNorm, StFinish, StOut
  } state_e;

  typedef enum logic [2:0] {LIdle, LNorm, LSq, LMul, LDone} lstate_e;
endpackage

@@ hw/rtl/svpm_ram.sv @@
// Generic single-port RAM with registered read.
// Depends on nothing.
module svpm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ hw/rtl/svpm_log_unit.sv @@
// Iterative peak-to-level unit: log2 by repeated squaring, then scale.
// Depends on svpm_pkg and the defines header.
`include "stereo_vu_peak_meter_defines.svh"
module svpm_log_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [svpm_pkg::MagW-1:0]  peak_i,
  output logic                       done_o,
  output logic [16:0]                level_o
);
  svpm_pkg::lstate_e st_q, st_d;
  logic [31:0] m_q, m_d;
  logic [4:0]  e_q, e_d;
  logic [4:0]  k_q, k_d;
  logic [15:0] frac_q, frac_d;
  logic [16:0] lvl_q, lvl_d;
  logic [63:0] sq;
  logic [33:0] sqs;
  logic [20:0] dval;
  logic [52:0] prod;
  logic [20:0] drop;
  logic [33:0] small_chk;

  assign sq = 64'(m_q) * 64'(m_q);
  assign sqs = sq[63:30];
  assign dval = 21'((21'(svpm_pkg::FracBits) << 16) - {e_q, frac_q});
  assign prod = 53'(dval) * 53'(svpm_pkg::Log10HalfQ32);
  assign drop = prod[52:32];
  assign small_chk = 34'(peak_i) * 34'd1000;

  always_comb begin
    st_d = st_q;
    case (st_q)
      svpm_pkg::LIdle: if (start_i) st_d = (small_chk < 34'(1 << svpm_pkg::FracBits)
                || peak_i >= svpm_pkg::MagW'(1 << svpm_pkg::FracBits)) ? svpm_pkg::LDone
                                                                      : svpm_pkg::LNorm;
      svpm_pkg::LNorm: if (m_q[30]) st_d = svpm_pkg::LSq;
      svpm_pkg::LSq:   if (k_q == 5'd15) st_d = svpm_pkg::LMul;
      svpm_pkg::LMul:  st_d = svpm_pkg::LDone;
      svpm_pkg::LDone: st_d = svpm_pkg::LIdle;
      default: st_d = svpm_pkg::LIdle;
    endcase
  end

  always_comb begin
    m_d = m_q; e_d = e_q; k_d = k_q; frac_d = frac_q; lvl_d = lvl_q;
    case (st_q)
      svpm_pkg::LIdle: begin
        m_d = 32'(peak_i); e_d = 5'd30; k_d = '0; frac_d = '0;
        lvl_d = (peak_i >= svpm_pkg::MagW'(1 << svpm_pkg::FracBits)) ? 17'd65536 : 17'd0;
      end
      svpm_pkg::LNorm: if (!m_q[30]) begin
        m_d = m_q << 1; e_d = e_q - 5'd1;
      end
      svpm_pkg::LSq: begin
        k_d = k_q + 5'd1;
        if (sqs[31]) begin
          m_d = sqs[32:1]; frac_d = {frac_q[14:0], 1'b1};
        end else begin
          m_d = sqs[31:0]; frac_d = {frac_q[14:0], 1'b0};
        end
      end
      svpm_pkg::LMul: lvl_d = (drop >= 21'd65536) ? 17'd0 : 17'(21'd65536 - drop);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= svpm_pkg::LIdle;
    else st_q <= st_d;
  end
  always_ff @(posedge clk_i) begin
    m_q <= m_d; e_q <= e_d; k_q <= k_d; frac_q <= frac_d; lvl_q <= lvl_d;
  end
  assign done_o = (st_q == svpm_pkg::LDone);
  assign level_o = lvl_q;

  `SVPM_ASSERT(a_norm_top, clk_i, rst_ni, (st_q == svpm_pkg::LSq) |-> m_q[30], "mantissa not normalized")
  `SVPM_ASSERT(a_lvl_rng, clk_i, rst_ni, done_o |-> (level_o <= 17'd65536), "level out of range")
  `SVPM_ASSERT(a_start_idle, clk_i, rst_ni, (st_q != svpm_pkg::LIdle) |=> (st_q != svpm_pkg::LIdle) || $past(st_q == svpm_pkg::LDone), "unit left busy state early")
endmodule

@@ hw/rtl/stereo_vu_peak_meter.sv @@
// Top level of the stereo peak program meter with clip hold.
// Depends on svpm_pkg, svpm_ram, svpm_log_unit and the defines header.
//
//  channel  dir  handshake               payload
//  s_axis   in   s_axis_tvalid/tready    tuser=opcode, tdata=left,right
//  m_axis   out  m_axis_tvalid/tready    tdata=bars,levels,clips
//  cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// A sample push is written to the ring when it is accepted. A frame tick takes its
// accept, then a registered RAM read and a compare for each scanned ring entry
// over min(window_len, fill) entries, then runs the shared log unit once per channel
// (the unit skips the log steps when the peak is below the floor or at full scale),
// packs the result, and holds it until the result transfer.
// Reset clears the write pointer, fill, hold counters and levels; ring content is
// left as is. Input is not ready while a tick is in work or its result waits.
`include "stereo_vu_peak_meter_defines.svh"
module stereo_vu_peak_meter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: [23:0] sample_left, [47:24] sample_right
  input  logic [47:0] s_axis_tdata,
  // tuser: [0] opcode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: [4:0] bar_left, [9:5] bar_right, [26:10] level_left,
  // [43:27] level_right, [44] clip_left, [45] clip_right, zero fill to 48
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);
  localparam int unsigned AW = svpm_pkg::AddrW;
  localparam int unsigned CW = svpm_pkg::CntW;
  localparam int unsigned SW = svpm_pkg::SampleWidth;

  svpm_pkg::state_e st_q, st_d;
  logic [12:0] win_q;
  logic [4:0]  bar_q, hold_t_q;
  logic [16:0] decay_q;
  logic [AW-1:0] wpos_q, idx_q, idx_d;
  logic [CW-1:0] fill_q, cnt_q, cnt_d;
  logic [SW-1:0] pl_q, pr_q, pl_d, pr_d;
  logic [4:0]  hl_q, hr_q, hl_d, hr_d;
  logic [16:0] sl_q, sr_q, sl_d, sr_d;
  logic        ch_q, ch_d;
  logic [47:0] out_q, out_d;
  logic        push, tick;
  logic [AW-1:0] ram_addr;
  logic [2*SW-1:0] ram_rd;
  logic [SW-1:0] al, ar, rl, rr;
  logic        log_start, log_done;
  logic [16:0] log_lvl;
  logic [SW-1:0] log_peak;
  logic [CW-1:0] nwin;
  logic [4:0]  bl;
  logic [21:0] vl, vr;
  logic [16:0] nsm;
  logic [4:0]  nhold;
  logic [SW-1:0] pk;
  logic [16:0] cur;
  logic [4:0]  curh;

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (st_q == svpm_pkg::StIdle);
  assign push = s_axis_tvalid && s_axis_tready && (s_axis_tuser == svpm_pkg::OpPush);
  assign tick = s_axis_tvalid && s_axis_tready && (s_axis_tuser == svpm_pkg::OpTick);
  assign ram_addr = push ? wpos_q : idx_q;

  svpm_ram #(.Width(2 * SW), .Depth(svpm_pkg::RingDepth)) u_ring (
    .clk_i(clk_i), .we_i(push), .addr_i(ram_addr),
    .wdata_i(s_axis_tdata), .rdata_o(ram_rd)
  );

  // Magnitude of a two's complement sample, wrapping like the reference.
  assign rl = ram_rd[SW-1:0];
  assign rr = ram_rd[2*SW-1:SW];
  assign al = rl[SW-1] ? SW'(-rl) : rl;
  assign ar = rr[SW-1] ? SW'(-rr) : rr;

  assign log_peak = ch_q ? pr_q : pl_q;
  assign log_start = (st_q == svpm_pkg::StLogInit);
  svpm_log_unit u_log (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(log_start), .peak_i(log_peak),
    .done_o(log_done), .level_o(log_lvl)
  );

  assign nwin = (CW'(win_q) > fill_q) ? fill_q : CW'(win_q);
  assign bl = (bar_q < 5'd5) ? 5'd5 : ((bar_q > 5'd24) ? 5'd24 : bar_q);

  // Smoothing and hold update for the channel the log unit just finished.
  assign pk = ch_q ? pr_q : pl_q;
  assign cur = ch_q ? sr_q : sl_q;
  assign curh = ch_q ? hr_q : hl_q;
  assign nsm = (log_lvl > cur) ? log_lvl : ((cur > decay_q) ? cur - decay_q : 17'd0);
  assign nhold = (pk > SW'(1 << svpm_pkg::FracBits)) ? hold_t_q
               : ((curh != 5'd0) ? curh - 5'd1 : 5'd0);

  assign vl = 22'(sl_q) * 22'(bl);
  assign vr = 22'(sr_q) * 22'(bl);

  // Next state.
  always_comb begin
    st_d = st_q;
    case (st_q)
      svpm_pkg::StIdle:   if (tick) st_d = (nwin == '0) ? svpm_pkg::StLogInit
                                                       : svpm_pkg::StScanRd;
      svpm_pkg::StScanRd: st_d = svpm_pkg::StScan;
      svpm_pkg::StScan:   if (cnt_q == CW'(1)) st_d = svpm_pkg::StLogInit;
                          else st_d = svpm_pkg::StScanRd;
      svpm_pkg::StLogInit: st_d = svpm_pkg::StLogNorm;
      svpm_pkg::StLogNorm: if (log_done) st_d = ch_q ? svpm_pkg::StFinish
                                                     : svpm_pkg::StLogInit;
      svpm_pkg::StFinish: st_d = svpm_pkg::StOut;
      svpm_pkg::StOut:    if (m_axis_tready) st_d = svpm_pkg::StIdle;
      default: st_d = svpm_pkg::StIdle;
    endcase
  end

  // Datapath updates.
  always_comb begin
    idx_d = idx_q; cnt_d = cnt_q; pl_d = pl_q; pr_d = pr_q;
    hl_d = hl_q; hr_d = hr_q; sl_d = sl_q; sr_d = sr_q; ch_d = ch_q; out_d = out_q;
    case (st_q)
      svpm_pkg::StIdle: if (tick) begin
        idx_d = wpos_q - AW'(1); cnt_d = nwin; pl_d = '0; pr_d = '0; ch_d = 1'b0;
      end
      svpm_pkg::StScan: begin
        if (al > pl_q) pl_d = al;
        if (ar > pr_q) pr_d = ar;
        idx_d = idx_q - AW'(1);
        cnt_d = cnt_q - CW'(1);
      end
      svpm_pkg::StLogNorm: if (log_done) begin
        if (ch_q) begin
          sr_d = nsm; hr_d = nhold;
        end else begin
          sl_d = nsm; hl_d = nhold; ch_d = 1'b1;
        end
      end
      svpm_pkg::StFinish: begin
        out_d = {2'b0, hr_q != 5'd0, hl_q != 5'd0, sr_q, sl_q,
                 (vr[21:16] > 6'(bl)) ? bl : vr[20:16],
                 (vl[21:16] > 6'(bl)) ? bl : vl[20:16]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= svpm_pkg::StIdle;
      win_q <= 13'd2205; bar_q <= 5'd24; hold_t_q <= 5'd20; decay_q <= 17'd1966;
      wpos_q <= '0; fill_q <= '0;
      hl_q <= '0; hr_q <= '0; sl_q <= '0; sr_q <= '0;
    end else begin
      st_q <= st_d;
      hl_q <= hl_d; hr_q <= hr_d; sl_q <= sl_d; sr_q <= sr_d;
      if (push) begin
        wpos_q <= wpos_q + AW'(1);
        if (fill_q < CW'(svpm_pkg::RingDepth)) fill_q <= fill_q + CW'(1);
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          svpm_pkg::RegWindow: win_q <= cfg_data_i[12:0];
          svpm_pkg::RegBar:    bar_q <= cfg_data_i[4:0];
          svpm_pkg::RegHold:   hold_t_q <= cfg_data_i[4:0];
          svpm_pkg::RegDecay:  decay_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload registers: hold their values outside the updates above.
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; cnt_q <= cnt_d; pl_q <= pl_d; pr_q <= pr_d;
    ch_q <= ch_d; out_q <= out_d;
  end

  assign m_axis_tvalid = (st_q == svpm_pkg::StOut);
  assign m_axis_tdata = out_q;

  `SVPM_ASSERT(a_busy_no_ready, clk_i, rst_ni, (st_q != svpm_pkg::StIdle) |-> !s_axis_tready, "input ready while busy")
  `SVPM_HOLD(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tdata, "result changed while stalled")
  `SVPM_ASSERT(a_fill_max, clk_i, rst_ni, fill_q <= CW'(svpm_pkg::RingDepth), "fill count overflow")
endmodule

@@ tb/sv/svpm_checker.sv @@
// Result checker for the stereo peak meter: watches stream and register transfers,
// predicts every meter frame and compares it field by field. Depends on svpm_pkg.
`timescale 1ns / 100ps
module svpm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [47:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  output int          err_count_o,
  output int          pending_o,
  output int          frames_o
);
  typedef struct packed {
    logic [4:0]  bar_l;
    logic [4:0]  bar_r;
    logic [16:0] lvl_l;
    logic [16:0] lvl_r;
    logic        clip_l;
    logic        clip_r;
  } frame_t;

  localparam longint unsigned One = 64'd1 << svpm_pkg::FracBits;

  logic [svpm_pkg::RingW-1:0] ring_q [svpm_pkg::RingDepth];
  logic [svpm_pkg::AddrW-1:0] wpos_q;
  logic [svpm_pkg::CntW-1:0]  fill_q;
  logic [4:0]       hold_l_q, hold_r_q;
  logic [16:0]      smooth_l_q, smooth_r_q;
  logic [12:0]      window_q;
  logic [4:0]       bar_q, hold_ticks_q;
  logic [16:0]      decay_q;
  frame_t           frames_due [$];

  function automatic longint unsigned magnitude(logic [svpm_pkg::SampleWidth-1:0] raw);
    if (raw[svpm_pkg::SampleWidth-1]) return (64'd1 << svpm_pkg::SampleWidth) - raw;
    return raw;
  endfunction

  // Peak to Q16 level through a fixed-point log2.
  function automatic logic [16:0] peak_level(longint unsigned p);
    longint unsigned m, lq, d, drop;
    int unsigned e;
    logic [15:0] frac;
    if (p * 1000 < One) return 17'd0;
    if (p >= One) return 17'd65536;
    e = 0;
    while (e < 63 && (p >> (e + 1)) != 0) e++;
    m = p << (30 - e);
    frac = '0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    lq = (longint'(e) << 16) | frac;
    d = (longint'(svpm_pkg::FracBits) << 16) - lq;
    drop = (d * longint'(svpm_pkg::Log10HalfQ32)) >> 32;
    if (drop >= 65536) return 17'd0;
    return 17'(65536 - drop);
  endfunction

  function automatic logic [16:0] smoothed(logic [16:0] cur, logic [16:0] lvl);
    if (lvl > cur) return lvl;
    return (cur > decay_q) ? cur - decay_q : 17'd0;
  endfunction

  function automatic logic [4:0] held(logic [4:0] hold, longint unsigned p);
    if (p > One) return hold_ticks_q;
    return (hold > 0) ? hold - 5'd1 : 5'd0;
  endfunction

  function automatic logic [4:0] bar_cells(logic [16:0] lvl, int unsigned bl);
    longint unsigned v;
    v = (longint'(lvl) * bl) >> 16;
    if (v > bl) v = bl;
    return 5'(v);
  endfunction

  task automatic flag(string what, longint unsigned want, longint unsigned got);
    if (err_count_o < 10)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
    err_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    automatic longint unsigned pl, pr, a, b;
    automatic int unsigned n, bl;
    automatic logic [svpm_pkg::AddrW-1:0] idx;
    automatic frame_t f, got;
    if (!rst_ni) begin
      wpos_q = '0; fill_q = '0;
      hold_l_q = '0; hold_r_q = '0;
      smooth_l_q = '0; smooth_r_q = '0;
      window_q = 13'd2205; bar_q = 5'd24; hold_ticks_q = 5'd20; decay_q = 17'd1966;
      err_count_o = 0; frames_o = 0; pending_o = 0;
      frames_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          svpm_pkg::RegWindow: window_q = cfg_data_i[12:0];
          svpm_pkg::RegBar:    bar_q = cfg_data_i[4:0];
          svpm_pkg::RegHold:   hold_ticks_q = cfg_data_i[4:0];
          svpm_pkg::RegDecay:  decay_q = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == svpm_pkg::OpPush) begin
          ring_q[wpos_q] = s_axis_tdata;
          wpos_q = wpos_q + 1'b1;
          if (fill_q < svpm_pkg::RingDepth) fill_q = fill_q + 1'b1;
        end else if (s_axis_tuser == svpm_pkg::OpTick) begin
          n = (window_q > fill_q) ? fill_q : window_q;
          pl = 0; pr = 0; idx = wpos_q;
          for (int unsigned i = 0; i < n; i++) begin
            idx = idx - 1'b1;
            a = magnitude(ring_q[idx][svpm_pkg::SampleWidth-1:0]);
            b = magnitude(ring_q[idx][svpm_pkg::RingW-1:svpm_pkg::SampleWidth]);
            if (a > pl) pl = a;
            if (b > pr) pr = b;
          end
          hold_l_q = held(hold_l_q, pl);
          hold_r_q = held(hold_r_q, pr);
          smooth_l_q = smoothed(smooth_l_q, peak_level(pl));
          smooth_r_q = smoothed(smooth_r_q, peak_level(pr));
          bl = (bar_q < 5) ? 5 : (bar_q > 24) ? 24 : bar_q;
          f.bar_l = bar_cells(smooth_l_q, bl);
          f.bar_r = bar_cells(smooth_r_q, bl);
          f.lvl_l = smooth_l_q;
          f.lvl_r = smooth_r_q;
          f.clip_l = (hold_l_q != 0);
          f.clip_r = (hold_r_q != 0);
          frames_due.push_back(f);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.bar_l = m_axis_tdata[4:0];
        got.bar_r = m_axis_tdata[9:5];
        got.lvl_l = m_axis_tdata[26:10];
        got.lvl_r = m_axis_tdata[43:27];
        got.clip_l = m_axis_tdata[44];
        got.clip_r = m_axis_tdata[45];
        frames_o++;
        if (frames_due.size() == 0) begin
          flag("unexpected frame, data", 0, m_axis_tdata);
        end else begin
          f = frames_due.pop_front();
          if (got.bar_l != f.bar_l) flag("bar_left", f.bar_l, got.bar_l);
          if (got.bar_r != f.bar_r) flag("bar_right", f.bar_r, got.bar_r);
          if (got.lvl_l != f.lvl_l) flag("level_left", f.lvl_l, got.lvl_l);
          if (got.lvl_r != f.lvl_r) flag("level_right", f.lvl_r, got.lvl_r);
          if (got.clip_l != f.clip_l) flag("clip_left", f.clip_l, got.clip_l);
          if (got.clip_r != f.clip_r) flag("clip_right", f.clip_r, got.clip_r);
        end
      end
      pending_o = frames_due.size();
    end
  end
endmodule

@@ tb/sv/tb_top.sv @@
// Stimulus top for the stereo peak meter: drives samples, frame ticks and
// register writes, and gives the verdict. Depends on svpm_pkg and svpm_checker.
`timescale 1ns / 100ps
module tb_top;
  localparam int Limit = 3000000;
  localparam int SettleCycles = 16;

  logic        clk, rst_n;
  logic        s_tvalid, s_tready, s_tuser;
  logic [47:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [47:0] m_tdata;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;
  int          err_count, pending, frames;
  int          cycles = 0;
  int          items = 0;
  int          tx_max = 13;
  int          rx_max = 13;
  int          rx_wait = 0;
  logic        took = 1'b0;

  stereo_vu_peak_meter dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  svpm_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready),
    .s_axis_tdata(s_tdata), .s_axis_tuser(s_tuser),
    .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .err_count_o(err_count), .pending_o(pending), .frames_o(frames)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // Bail out if the block stops making progress.
  always @(posedge clk) begin
    cycles++;
    if (cycles > Limit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: note each result transfer, then stall a random number of cycles.
  always @(posedge clk) took <= m_tvalid && m_tready;

  always @(negedge clk) begin
    if (took) rx_wait = $urandom_range(0, rx_max);
    if (rx_wait > 0) begin
      m_tready = 1'b0;
      rx_wait--;
    end else begin
      m_tready = 1'b1;
    end
  end

  // Mix of magnitudes: full range, small values, near unity, extremes.
  function automatic logic [23:0] rand_sample();
    logic [23:0] mag;
    int unsigned sh;
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: begin
        sh = $urandom_range(1, 21);
        mag = 24'($urandom) & ((24'd1 << sh) - 24'd1);
        return $urandom_range(0, 1) ? -mag : mag;
      end
      2: begin
        mag = 24'((1 << 20) + $urandom_range(0, 40) - 20);
        return $urandom_range(0, 1) ? -mag : mag;
      end
      default: return $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
    endcase
  endfunction

  // Send one item after a random gap; hold it until the transfer.
  task automatic send(logic op, logic [23:0] left, logic [23:0] right);
    int gap;
    gap = $urandom_range(0, tx_max);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = {right, left};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items++;
  endtask

  task automatic release_bus();
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Wait until every predicted frame has come back, then let the block settle.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic setup(logic [16:0] win, logic [16:0] bar, logic [16:0] hold,
                       logic [16:0] decay);
    release_bus();
    drain();
    write_reg(svpm_pkg::RegWindow, win);
    write_reg(svpm_pkg::RegBar, bar);
    write_reg(svpm_pkg::RegHold, hold);
    write_reg(svpm_pkg::RegDecay, decay);
  endtask

  // Random traffic; tick data bits are noise the block ignores.
  task automatic burst(int count, int tick_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 59) == 0) begin
        release_bus();
        drain();
      end
      if ($urandom_range(0, 99) < tick_pct)
        send(svpm_pkg::OpTick, 24'($urandom), 24'($urandom));
      else
        send(svpm_pkg::OpPush, rand_sample(), rand_sample());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    s_tvalid = 1'b0; s_tuser = svpm_pkg::OpPush; s_tdata = '0;
    m_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = svpm_pkg::RegWindow; cfg_data = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty ring, sample extremes, unity, clip edge, level floor.
    send(svpm_pkg::OpTick, 24'h0, 24'h0);
    send(svpm_pkg::OpPush, 24'h800000, 24'h7FFFFF);
    send(svpm_pkg::OpTick, 24'h0, 24'h0);
    send(svpm_pkg::OpPush, 24'h000000, 24'h000000);
    send(svpm_pkg::OpTick, 24'h0, 24'h0);
    send(svpm_pkg::OpPush, 24'h100000, 24'hF00000);
    send(svpm_pkg::OpPush, 24'h100001, 24'h000418);
    send(svpm_pkg::OpTick, 24'h0, 24'h0);
    send(svpm_pkg::OpPush, 24'h000418, 24'h000419);
    send(svpm_pkg::OpPush, 24'h0FFFFF, 24'hEFFFFF);
    send(svpm_pkg::OpTick, 24'hFFFFFF, 24'hFFFFFF);
    send(svpm_pkg::OpPush, 24'hFFFBE8, 24'h000001);
    send(svpm_pkg::OpTick, 24'h0, 24'h0);
    send(svpm_pkg::OpTick, 24'h0, 24'h0);

    // Window zero, clamped short bar, no hold, no decay.
    setup(17'd0, 17'd0, 17'd0, 17'd0);
    burst(80, 15);
    // Window of one, clamped long bar, longest hold, widest decay.
    setup(17'd1, 17'h1FFFF, 17'd31, 17'h1FFFF);
    burst(120, 15);
    // Back-to-back traffic with no stalls on either side.
    tx_max = 0; rx_max = 0;
    setup(17'd7, 17'h1FFE5, 17'd3, 17'd65536);
    burst(150, 15);
    tx_max = 13; rx_max = 13;
    setup(17'd37, 17'd24, 17'd1, 17'd500);
    burst(200, 15);
    setup(17'd200, 17'd13, 17'd20, 17'd1966);
    burst(200, 15);
    // Window beyond the fill count; only written entries are scanned.
    setup(17'h1FFFF, 17'd17, 17'd9, 17'd3000);
    burst(150, 12);

    // Scan everything written so far with the largest windows.
    setup(17'd4096, 17'd24, 17'd20, 17'd1966);
    send(svpm_pkg::OpTick, 24'h0, 24'h0);
    setup(17'h1FFFF, 17'd10, 17'd5, 17'd9000);
    send(svpm_pkg::OpTick, 24'h0, 24'h0);
    for (int i = 0; i < 6; i++) begin
      send(svpm_pkg::OpPush, rand_sample(), rand_sample());
      send(svpm_pkg::OpTick, 24'h0, 24'h0);
    end

    release_bus();
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("run covered %0d input transfers and %0d meter frames", items, frames);
    $display("over window, bar, hold and decay settings including both extremes");
    if (err_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d frames missing", err_count, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
